/* hdl/mpsm_pkg.sv */
package mpsm_pkg;

   localparam int NODES    = 1024;
   localparam int PATTERNS = 256;
   localparam int MAX_LEN  = 32;
   localparam int MAX_RES  = 64;

   localparam int NODE_W = $clog2(NODES);
   localparam int NCNT_W = NODE_W + 1;
   localparam int PAT_W  = 8;
   localparam int PCNT_W = $clog2(PATTERNS) + 1;
   localparam int PADR_W = $clog2(PATTERNS);
   localparam int LEN_W  = 6;
   localparam int SYM_W  = 8;
   localparam int KIND_W = 3;
   localparam int STAT_W = 3;
   localparam int POS_W  = 32;
   localparam int RES_W  = $clog2(MAX_RES) + 1;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR        = 3'd0,
      KIND_PATTERN_BYTE = 3'd1,
      KIND_PATTERN_END  = 3'd2,
      KIND_BUILD        = 3'd3,
      KIND_TEXT_START   = 3'd4,
      KIND_TEXT_BYTE    = 3'd5
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE          = 3'd0,
      ST_MATCH         = 3'd1,
      ST_NODES_FULL    = 3'd2,
      ST_PATTERNS_FULL = 3'd3,
      ST_TOO_LONG      = 3'd4,
      ST_TEXT_LONG     = 3'd5
   } status_type;

   typedef struct packed {
      logic [NODE_W-1:0] parent;
      logic [SYM_W-1:0]  sym;
      logic [LEN_W-1:0]  depth;
   } key_type;

   typedef struct packed {
      logic              fail_nil;
      logic [NODE_W-1:0] fail;
      logic              out_none;
      logic [PAT_W-1:0]  out_id;
   } link_type;

endpackage

/* hdl/mpsm_if.sv */
interface mpsm_req_if;
   logic                            valid;
   logic                            ready;
   logic [mpsm_pkg::KIND_W-1:0]     kind;
   logic [mpsm_pkg::SYM_W-1:0]      symbol;

   modport source (output valid, output kind, output symbol, input ready);
   modport sink (input valid, input kind, input symbol, output ready);
endinterface

interface mpsm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mpsm_pkg::STAT_W-1:0]     status;
   logic [mpsm_pkg::PAT_W-1:0]      pattern_id;
   logic [mpsm_pkg::POS_W-1:0]      start_position;
   logic                            last;

   modport source (output valid, output status, output pattern_id, output start_position,
                   output last, input ready);
   modport sink (input valid, input status, input pattern_id, input start_position,
                 input last, output ready);
endinterface

/* hdl/mpsm_ram.sv */
module mpsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* hdl/multi_pattern_string_matcher_core.sv */
// Aho-Corasick matcher over a trie held in block memories. Each request is taken while the
// block is idle and answered with one response, or with one response per distinct pattern
// found for a text byte (up to 64), the final one flagged by last. Every child lookup sweeps
// the node table at one entry per cycle, so a pattern byte costs at most one sweep and a text
// byte one sweep plus one per failure step taken, followed by a walk along the output chain. A
// build makes an output clean-up pass over the nodes plus 32 passes over the node table, one
// per level, and each node below the first level adds one lookup sweep per failure step.
// Clear and reset take effect at once: entries beyond the node count are rewritten when
// their node is created, so no clearing pass runs.
module multi_pattern_string_matcher_core (
   input  logic       clock,
   input  logic       reset,
   mpsm_req_if.sink   req_ch,
   mpsm_rsp_if.source rsp_ch
);

   typedef enum logic [4:0] {
      S_IDLE, S_EMIT, S_SCAN, S_PB_DONE, S_PE_RD, S_PE_WAIT, S_PE_LEN,
      S_B_PRE_RD, S_B_PRE_WAIT, S_B_PRE_LEN, S_B_LV_RD, S_B_LV_WAIT, S_B_PAR_WAIT,
      S_B_SRCH_RET, S_B_FAIL_WAIT, S_B_OUT_WAIT,
      S_T_SRCH_RET, S_T_FAIL_WAIT, S_T_OUT_RD, S_T_OUT_WAIT, S_T_LEN_WAIT, S_T_FINAL
   } state_type;

   state_type                         state_ff, ret_ff;
   logic [mpsm_pkg::SYM_W-1:0]        sym_ff, ssym_ff;
   logic [mpsm_pkg::NCNT_W-1:0]       node_count_ff, sa_ff, v_ff;
   logic [mpsm_pkg::PCNT_W-1:0]       pat_count_ff;
   logic [mpsm_pkg::NODE_W-1:0]       ins_node_ff, match_node_ff, sp_ff, sd_ff;
   logic [mpsm_pkg::NODE_W-1:0]       hit_idx_ff, fidx_ff;
   logic [mpsm_pkg::LEN_W-1:0]        ins_len_ff, lvl_ff;
   logic [mpsm_pkg::POS_W-1:0]        text_pos_ff, pend_start_ff, rsp_start_ff;
   logic                              out0_none_ff, sv_ff, hit_ff, lz_ff;
   logic [mpsm_pkg::PAT_W-1:0]        out0_id_ff, prev_id_ff, pend_id_ff, em_id_ff, rsp_id_ff;
   logic                              prev_none_ff, pend_valid_ff, rsp_valid_ff, rsp_last_ff;
   logic [mpsm_pkg::RES_W-1:0]        cnt_ff;
   mpsm_pkg::status_type              em_st_ff, rsp_status_ff;
   mpsm_pkg::key_type                 cur_key_ff, key_rd, key_wdata;
   mpsm_pkg::link_type                cur_link_ff, link_rd, link_wdata, pe_link, root_link;

   logic [$bits(mpsm_pkg::key_type)-1:0]  key_q;
   logic [$bits(mpsm_pkg::link_type)-1:0] link_q;
   logic [mpsm_pkg::LEN_W-1:0]            plen_rd, plen_wdata;
   logic [mpsm_pkg::NODE_W-1:0]           key_raddr, link_raddr, link_waddr;
   logic [mpsm_pkg::PADR_W-1:0]           plen_raddr;
   logic                                  key_we, link_we, plen_we;
   logic                                  out_free, pe_old, pe_new, pe_full, key_hit;
   logic                                  rsp_load;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_load  = out_free && ((state_ff == S_EMIT) || (state_ff == S_T_FINAL) ||
                                   ((state_ff == S_T_LEN_WAIT) && pend_valid_ff));
   assign root_link = '{fail_nil: 1'b1, fail: '0, out_none: out0_none_ff, out_id: out0_id_ff};
   assign key_rd    = mpsm_pkg::key_type'(key_q);
   assign link_rd   = lz_ff ? root_link : mpsm_pkg::link_type'(link_q);
   assign pe_link   = (state_ff == S_PE_WAIT) ? link_rd : cur_link_ff;
   assign pe_full   = pat_count_ff >= mpsm_pkg::PCNT_W'(mpsm_pkg::PATTERNS);
   assign pe_old    = ((state_ff == S_PE_WAIT) && !link_rd.out_none && (ins_node_ff == '0)) ||
                      ((state_ff == S_PE_LEN) && (plen_rd == ins_len_ff));
   assign pe_new    = ((state_ff == S_PE_WAIT) && link_rd.out_none) ||
                      ((state_ff == S_PE_LEN) && (plen_rd != ins_len_ff));
   assign key_hit   = sv_ff && (key_rd.parent == sp_ff) && (key_rd.sym == ssym_ff);

   assign req_ch.ready          = (state_ff == S_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.pattern_id     = rsp_id_ff;
   assign rsp_ch.start_position = rsp_start_ff;
   assign rsp_ch.last           = rsp_last_ff;

   always_comb begin
      key_raddr = v_ff[mpsm_pkg::NODE_W-1:0];
      if (state_ff == S_SCAN) begin
         key_raddr = sa_ff[mpsm_pkg::NODE_W-1:0];
      end
      key_we    = (state_ff == S_PB_DONE) && !hit_ff &&
                  (node_count_ff < mpsm_pkg::NCNT_W'(mpsm_pkg::NODES));
      key_wdata = '{parent: ins_node_ff, sym: sym_ff, depth: ins_len_ff + 1'b1};

      case (state_ff)
         S_PE_RD:                      link_raddr = ins_node_ff;
         S_B_LV_WAIT:                  link_raddr = key_rd.parent;
         S_B_SRCH_RET, S_T_SRCH_RET:   link_raddr = hit_ff ? hit_idx_ff : sp_ff;
         S_T_OUT_RD:                   link_raddr = fidx_ff;
         default:                      link_raddr = v_ff[mpsm_pkg::NODE_W-1:0];
      endcase

      case (state_ff)
         S_PE_WAIT, S_B_PRE_WAIT, S_T_OUT_WAIT: plen_raddr = link_rd.out_id;
         default:                               plen_raddr = cur_link_ff.out_id;
      endcase

      plen_we    = pe_new && !pe_full;
      plen_wdata = (ins_len_ff == '0) ? mpsm_pkg::LEN_W'(1) : ins_len_ff;

      link_we    = 1'b0;
      link_waddr = v_ff[mpsm_pkg::NODE_W-1:0];
      link_wdata = '{fail_nil: 1'b1, fail: '0, out_none: 1'b1, out_id: '0};
      case (state_ff)
         S_PB_DONE: begin
            link_we    = key_we;
            link_waddr = node_count_ff[mpsm_pkg::NODE_W-1:0];
         end
         S_PE_WAIT, S_PE_LEN: begin
            link_we           = pe_new && !pe_full && (ins_node_ff != '0);
            link_waddr        = ins_node_ff;
            link_wdata        = pe_link;
            link_wdata.out_none = 1'b0;
            link_wdata.out_id = pat_count_ff[mpsm_pkg::PAT_W-1:0];
         end
         S_B_PRE_LEN: begin
            link_we             = (plen_rd != cur_key_ff.depth);
            link_wdata          = cur_link_ff;
            link_wdata.out_none = 1'b1;
         end
         S_B_LV_WAIT: begin
            link_we             = (key_rd.depth == lvl_ff) &&
                                  (lvl_ff == mpsm_pkg::LEN_W'(1));
            link_wdata.fail_nil = 1'b0;
            link_wdata.out_none = link_rd.out_none ? out0_none_ff : 1'b0;
            link_wdata.out_id   = link_rd.out_none ? out0_id_ff : link_rd.out_id;
         end
         S_B_OUT_WAIT: begin
            link_we             = 1'b1;
            link_wdata.fail_nil = 1'b0;
            link_wdata.fail     = fidx_ff;
            link_wdata.out_none = cur_link_ff.out_none ? link_rd.out_none : 1'b0;
            link_wdata.out_id   = cur_link_ff.out_none ? link_rd.out_id : cur_link_ff.out_id;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      lz_ff <= (link_raddr == '0);
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= mpsm_pkg::NCNT_W'(1);
         pat_count_ff  <= '0;
         ins_node_ff   <= '0;
         ins_len_ff    <= '0;
         match_node_ff <= '0;
         text_pos_ff   <= '0;
         out0_none_ff  <= 1'b1;
         pend_valid_ff <= 1'b0;
      end else begin
         if (rsp_ch.ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  sym_ff   <= req_ch.symbol;
                  em_id_ff <= '0;
                  case (req_ch.kind)
                     mpsm_pkg::KIND_CLEAR: begin
                        em_st_ff      <= mpsm_pkg::ST_DONE;
                        state_ff      <= S_EMIT;
                        node_count_ff <= mpsm_pkg::NCNT_W'(1);
                        pat_count_ff  <= '0;
                        ins_node_ff   <= '0;
                        ins_len_ff    <= '0;
                        match_node_ff <= '0;
                        text_pos_ff   <= '0;
                        out0_none_ff  <= 1'b1;
                     end
                     mpsm_pkg::KIND_PATTERN_BYTE: begin
                        if (ins_len_ff >= mpsm_pkg::LEN_W'(mpsm_pkg::MAX_LEN)) begin
                           em_st_ff <= mpsm_pkg::ST_TOO_LONG;
                           state_ff <= S_EMIT;
                        end else begin
                           em_st_ff <= mpsm_pkg::ST_DONE;
                           sp_ff    <= ins_node_ff;
                           ssym_ff  <= req_ch.symbol;
                           sa_ff    <= mpsm_pkg::NCNT_W'(1);
                           sv_ff    <= 1'b0;
                           ret_ff   <= S_PB_DONE;
                           state_ff <= S_SCAN;
                        end
                     end
                     mpsm_pkg::KIND_PATTERN_END: begin
                        em_st_ff <= mpsm_pkg::ST_DONE;
                        state_ff <= S_PE_RD;
                     end
                     mpsm_pkg::KIND_BUILD: begin
                        em_st_ff <= mpsm_pkg::ST_DONE;
                        v_ff     <= mpsm_pkg::NCNT_W'(1);
                        state_ff <= S_B_PRE_RD;
                     end
                     mpsm_pkg::KIND_TEXT_START: begin
                        em_st_ff      <= mpsm_pkg::ST_DONE;
                        state_ff      <= S_EMIT;
                        match_node_ff <= '0;
                        text_pos_ff   <= '0;
                     end
                     mpsm_pkg::KIND_TEXT_BYTE: begin
                        if (text_pos_ff == '1) begin
                           em_st_ff <= mpsm_pkg::ST_TEXT_LONG;
                           state_ff <= S_EMIT;
                        end else begin
                           em_st_ff      <= mpsm_pkg::ST_DONE;
                           sp_ff         <= match_node_ff;
                           ssym_ff       <= req_ch.symbol;
                           sa_ff         <= mpsm_pkg::NCNT_W'(1);
                           sv_ff         <= 1'b0;
                           ret_ff        <= S_T_SRCH_RET;
                           state_ff      <= S_SCAN;
                           cnt_ff        <= '0;
                           prev_none_ff  <= 1'b1;
                           pend_valid_ff <= 1'b0;
                        end
                     end
                     default: begin
                        em_st_ff <= mpsm_pkg::ST_DONE;
                        state_ff <= S_EMIT;
                     end
                  endcase
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= em_st_ff;
                  rsp_id_ff     <= em_id_ff;
                  rsp_start_ff  <= '0;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            S_SCAN: begin
               if (key_hit) begin
                  hit_ff     <= 1'b1;
                  hit_idx_ff <= sd_ff;
                  state_ff   <= ret_ff;
               end else if (sv_ff && ({1'b0, sd_ff} == node_count_ff - 1'b1)) begin
                  hit_ff   <= 1'b0;
                  state_ff <= ret_ff;
               end else if (sa_ff >= node_count_ff) begin
                  hit_ff   <= 1'b0;
                  state_ff <= ret_ff;
               end else begin
                  sd_ff <= sa_ff[mpsm_pkg::NODE_W-1:0];
                  sv_ff <= 1'b1;
                  sa_ff <= sa_ff + 1'b1;
               end
            end
            S_PB_DONE: begin
               state_ff <= S_EMIT;
               if (hit_ff) begin
                  ins_node_ff <= hit_idx_ff;
                  ins_len_ff  <= ins_len_ff + 1'b1;
               end else if (!key_we) begin
                  em_st_ff <= mpsm_pkg::ST_NODES_FULL;
               end else begin
                  ins_node_ff   <= node_count_ff[mpsm_pkg::NODE_W-1:0];
                  node_count_ff <= node_count_ff + 1'b1;
                  ins_len_ff    <= ins_len_ff + 1'b1;
               end
            end
            S_PE_RD: begin
               state_ff <= S_PE_WAIT;
            end
            S_PE_WAIT, S_PE_LEN: begin
               if (state_ff == S_PE_WAIT) begin
                  cur_link_ff <= link_rd;
               end
               if (pe_old || pe_new) begin
                  ins_node_ff <= '0;
                  ins_len_ff  <= '0;
                  state_ff    <= S_EMIT;
               end else begin
                  state_ff <= S_PE_LEN;
               end
               if (pe_old) begin
                  em_id_ff <= pe_link.out_id;
               end else if (pe_new) begin
                  if (pe_full) begin
                     em_st_ff <= mpsm_pkg::ST_PATTERNS_FULL;
                  end else begin
                     em_id_ff     <= pat_count_ff[mpsm_pkg::PAT_W-1:0];
                     pat_count_ff <= pat_count_ff + 1'b1;
                     if (ins_node_ff == '0) begin
                        out0_none_ff <= 1'b0;
                        out0_id_ff   <= pat_count_ff[mpsm_pkg::PAT_W-1:0];
                     end
                  end
               end
            end
            S_B_PRE_RD: begin
               if (v_ff >= node_count_ff) begin
                  lvl_ff   <= mpsm_pkg::LEN_W'(1);
                  v_ff     <= mpsm_pkg::NCNT_W'(1);
                  state_ff <= S_B_LV_RD;
               end else begin
                  state_ff <= S_B_PRE_WAIT;
               end
            end
            S_B_PRE_WAIT: begin
               cur_key_ff  <= key_rd;
               cur_link_ff <= link_rd;
               if (link_rd.out_none) begin
                  v_ff     <= v_ff + 1'b1;
                  state_ff <= S_B_PRE_RD;
               end else begin
                  state_ff <= S_B_PRE_LEN;
               end
            end
            S_B_PRE_LEN: begin
               v_ff     <= v_ff + 1'b1;
               state_ff <= S_B_PRE_RD;
            end
            S_B_LV_RD: begin
               if (v_ff >= node_count_ff) begin
                  if (lvl_ff == mpsm_pkg::LEN_W'(mpsm_pkg::MAX_LEN)) begin
                     state_ff <= S_EMIT;
                  end else begin
                     lvl_ff <= lvl_ff + 1'b1;
                     v_ff   <= mpsm_pkg::NCNT_W'(1);
                  end
               end else begin
                  state_ff <= S_B_LV_WAIT;
               end
            end
            S_B_LV_WAIT: begin
               cur_key_ff  <= key_rd;
               cur_link_ff <= link_rd;
               if ((key_rd.depth != lvl_ff) || (lvl_ff == mpsm_pkg::LEN_W'(1))) begin
                  v_ff     <= v_ff + 1'b1;
                  state_ff <= S_B_LV_RD;
               end else begin
                  state_ff <= S_B_PAR_WAIT;
               end
            end
            S_B_PAR_WAIT, S_B_FAIL_WAIT: begin
               sp_ff    <= link_rd.fail_nil ? '0 : link_rd.fail;
               ssym_ff  <= cur_key_ff.sym;
               sa_ff    <= mpsm_pkg::NCNT_W'(1);
               sv_ff    <= 1'b0;
               ret_ff   <= S_B_SRCH_RET;
               state_ff <= S_SCAN;
            end
            S_B_SRCH_RET: begin
               if (!hit_ff && (sp_ff != '0)) begin
                  state_ff <= S_B_FAIL_WAIT;
               end else begin
                  fidx_ff  <= hit_ff ? hit_idx_ff : '0;
                  state_ff <= S_B_OUT_WAIT;
               end
            end
            S_B_OUT_WAIT: begin
               v_ff     <= v_ff + 1'b1;
               state_ff <= S_B_LV_RD;
            end
            S_T_SRCH_RET: begin
               if (!hit_ff && (sp_ff != '0)) begin
                  state_ff <= S_T_FAIL_WAIT;
               end else begin
                  match_node_ff <= hit_ff ? hit_idx_ff : '0;
                  fidx_ff       <= hit_ff ? hit_idx_ff : '0;
                  state_ff      <= S_T_OUT_RD;
               end
            end
            S_T_FAIL_WAIT: begin
               sp_ff    <= link_rd.fail_nil ? '0 : link_rd.fail;
               ssym_ff  <= sym_ff;
               sa_ff    <= mpsm_pkg::NCNT_W'(1);
               sv_ff    <= 1'b0;
               ret_ff   <= S_T_SRCH_RET;
               state_ff <= S_SCAN;
            end
            S_T_OUT_RD: begin
               if (cnt_ff == mpsm_pkg::RES_W'(mpsm_pkg::MAX_RES)) begin
                  state_ff <= S_T_FINAL;
               end else begin
                  state_ff <= S_T_OUT_WAIT;
               end
            end
            S_T_OUT_WAIT: begin
               cur_link_ff <= link_rd;
               if (link_rd.out_none) begin
                  state_ff <= S_T_FINAL;
               end else if (prev_none_ff || (link_rd.out_id != prev_id_ff)) begin
                  state_ff <= S_T_LEN_WAIT;
               end else if (link_rd.fail_nil) begin
                  state_ff <= S_T_FINAL;
               end else begin
                  fidx_ff  <= link_rd.fail;
                  state_ff <= S_T_OUT_RD;
               end
            end
            S_T_LEN_WAIT: begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= mpsm_pkg::ST_MATCH;
                     rsp_id_ff     <= pend_id_ff;
                     rsp_start_ff  <= pend_start_ff;
                     rsp_last_ff   <= 1'b0;
                  end
                  pend_valid_ff <= 1'b1;
                  pend_id_ff    <= cur_link_ff.out_id;
                  pend_start_ff <= text_pos_ff + mpsm_pkg::POS_W'(1) -
                                   mpsm_pkg::POS_W'(plen_rd);
                  prev_none_ff  <= 1'b0;
                  prev_id_ff    <= cur_link_ff.out_id;
                  cnt_ff        <= cnt_ff + 1'b1;
                  if (cur_link_ff.fail_nil) begin
                     state_ff <= S_T_FINAL;
                  end else begin
                     fidx_ff  <= cur_link_ff.fail;
                     state_ff <= S_T_OUT_RD;
                  end
               end
            end
            S_T_FINAL: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_last_ff   <= 1'b1;
                  rsp_status_ff <= pend_valid_ff ? mpsm_pkg::ST_MATCH : mpsm_pkg::ST_DONE;
                  rsp_id_ff     <= pend_valid_ff ? pend_id_ff : '0;
                  rsp_start_ff  <= pend_valid_ff ? pend_start_ff : '0;
                  pend_valid_ff <= 1'b0;
                  text_pos_ff   <= text_pos_ff + 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   mpsm_ram #(
      .WIDTH($bits(mpsm_pkg::key_type)),
      .DEPTH(mpsm_pkg::NODES)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (key_we),
      .wr_addr(node_count_ff[mpsm_pkg::NODE_W-1:0]),
      .wr_data(key_wdata),
      .rd_addr(key_raddr),
      .rd_data(key_q)
   );

   mpsm_ram #(
      .WIDTH($bits(mpsm_pkg::link_type)),
      .DEPTH(mpsm_pkg::NODES)
   ) u_link_ram (
      .clock  (clock),
      .wr_en  (link_we),
      .wr_addr(link_waddr),
      .wr_data(link_wdata),
      .rd_addr(link_raddr),
      .rd_data(link_q)
   );

   mpsm_ram #(
      .WIDTH(mpsm_pkg::LEN_W),
      .DEPTH(mpsm_pkg::PATTERNS)
   ) u_plen_ram (
      .clock  (clock),
      .wr_en  (plen_we),
      .wr_addr(pat_count_ff[mpsm_pkg::PADR_W-1:0]),
      .wr_data(plen_wdata),
      .rd_addr(plen_raddr),
      .rd_data(plen_rd)
   );

endmodule

/* hdl/mpsm_checker.sv */
module mpsm_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mpsm_pkg::STAT_W-1:0]   rsp_status,
   input logic [mpsm_pkg::PAT_W-1:0]    rsp_pattern_id,
   input logic [mpsm_pkg::POS_W-1:0]    rsp_start_position,
   input logic                          rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
         $stable(rsp_pattern_id) && $stable(rsp_start_position) && $stable(rsp_last)))
      else $error("A stalled response changed before it was taken.");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("A new request was taken before the previous one was handled.");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != mpsm_pkg::ST_MATCH)) |-> (rsp_last &&
         (rsp_start_position == '0)))
      else $error("A non-match response was not a final response with zero start.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("A response was presented straight after reset.");

endmodule

bind multi_pattern_string_matcher_core mpsm_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_status        (rsp_ch.status),
   .rsp_pattern_id    (rsp_ch.pattern_id),
   .rsp_start_position(rsp_ch.start_position),
   .rsp_last          (rsp_ch.last)
);

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned NIL        = 32'hFFFF_FFFF;
   localparam int unsigned CYCLE_LIMIT = 6_000_000;

   typedef struct {
      logic [mpsm_pkg::STAT_W-1:0] status;
      logic [mpsm_pkg::PAT_W-1:0]  id;
      logic [mpsm_pkg::POS_W-1:0]  start;
      logic                        last;
   } match_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mpsm_req_if req_ch ();
   mpsm_rsp_if rsp_ch ();

   multi_pattern_string_matcher_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #5 clock = ~clock;

   // Shadow copy of the trie and matcher state.
   int unsigned trie_key[mpsm_pkg::NODES];
   int unsigned fail_to[mpsm_pkg::NODES];
   int unsigned out_id[mpsm_pkg::NODES];
   int unsigned pat_len[mpsm_pkg::PATTERNS];
   int unsigned walk_queue[mpsm_pkg::NODES];
   int unsigned n_nodes, n_patterns, ins_node, ins_len, cur_node, text_pos;

   match_result_type expected_results[$];
   int unsigned      errors = 0;
   int unsigned      cycles = 0;
   int unsigned      burst_left = 0;

   function automatic void trie_clear();
      for (int i = 0; i < mpsm_pkg::NODES; i++) begin
         fail_to[i] = NIL;
         out_id[i] = NIL;
      end
      n_nodes = 1;
      n_patterns = 0;
      ins_node = 0;
      ins_len = 0;
      cur_node = 0;
      text_pos = 0;
   endfunction

   function automatic int unsigned find_child(int unsigned u, int unsigned c);
      int unsigned key;
      key = (u << 8) | (c & 8'hFF);
      for (int unsigned v = 1; v < n_nodes && v < mpsm_pkg::NODES; v++)
         if (trie_key[v] == key) return v;
      return NIL;
   endfunction

   function automatic int unsigned node_depth(int unsigned v);
      int unsigned d;
      d = 0;
      while (v != 0 && v < mpsm_pkg::NODES && d < mpsm_pkg::NODES) begin
         v = trie_key[v] >> 8;
         d++;
      end
      return d;
   endfunction

   function automatic int unsigned id_length(int unsigned id);
      return id < mpsm_pkg::PATTERNS ? pat_len[id] : 0;
   endfunction

   function automatic void link_trie();
      int unsigned head, tail, u, c, r, t, guard;
      head = 0;
      tail = 0;
      for (int unsigned v = 1; v < n_nodes && v < mpsm_pkg::NODES; v++)
         if (out_id[v] != NIL && id_length(out_id[v]) != node_depth(v)) out_id[v] = NIL;
      fail_to[0] = NIL;
      for (int unsigned v = 1; v < n_nodes && v < mpsm_pkg::NODES; v++) begin
         if ((trie_key[v] >> 8) == 0) begin
            fail_to[v] = 0;
            if (out_id[v] == NIL) out_id[v] = out_id[0];
            if (tail < mpsm_pkg::NODES) walk_queue[tail++] = v;
         end
      end
      while (head < tail) begin
         u = walk_queue[head++];
         for (int unsigned v = 1; v < n_nodes && v < mpsm_pkg::NODES; v++) begin
            if ((trie_key[v] >> 8) != u) continue;
            c = trie_key[v] & 8'hFF;
            r = (u < mpsm_pkg::NODES) ? fail_to[u] : NIL;
            if (r == NIL || r >= mpsm_pkg::NODES) r = 0;
            t = find_child(r, c);
            guard = 0;
            while (t == NIL && r != 0 && guard < mpsm_pkg::NODES) begin
               r = fail_to[r];
               if (r == NIL || r >= mpsm_pkg::NODES) r = 0;
               t = find_child(r, c);
               guard++;
            end
            fail_to[v] = (t == NIL) ? 0 : t;
            if (out_id[v] == NIL) out_id[v] = out_id[fail_to[v]];
            if (tail < mpsm_pkg::NODES) walk_queue[tail++] = v;
         end
      end
   endfunction

   function automatic void push_result(int unsigned st, int unsigned id, int unsigned start,
                                       bit last);
      match_result_type m;
      m.status = st[mpsm_pkg::STAT_W-1:0];
      m.id = id[mpsm_pkg::PAT_W-1:0];
      m.start = start;
      m.last = last;
      expected_results.insert(expected_results.size(), m);
   endfunction

   function automatic void predict_matches(logic [mpsm_pkg::KIND_W-1:0] kind,
                                           logic [mpsm_pkg::SYM_W-1:0] sym);
      int unsigned st, id, v, n, o, node, t, guard, r, prev, k;
      st = mpsm_pkg::ST_DONE;
      id = 0;
      case (kind)
         mpsm_pkg::KIND_CLEAR: trie_clear();
         mpsm_pkg::KIND_PATTERN_BYTE: begin
            if (ins_len >= mpsm_pkg::MAX_LEN) begin
               st = mpsm_pkg::ST_TOO_LONG;
            end else begin
               v = find_child(ins_node, sym);
               if (v == NIL) begin
                  if (n_nodes >= mpsm_pkg::NODES) begin
                     st = mpsm_pkg::ST_NODES_FULL;
                  end else begin
                     v = n_nodes++;
                     trie_key[v] = (ins_node << 8) | sym;
                     fail_to[v] = NIL;
                     out_id[v] = NIL;
                  end
               end
               if (v != NIL) begin
                  ins_node = v;
                  ins_len++;
               end
            end
         end
         mpsm_pkg::KIND_PATTERN_END: begin
            n = ins_node < mpsm_pkg::NODES ? ins_node : 0;
            o = out_id[n];
            if (o != NIL && o < mpsm_pkg::PATTERNS && (n == 0 || pat_len[o] == ins_len)) begin
               id = o;
            end else if (n_patterns >= mpsm_pkg::PATTERNS) begin
               st = mpsm_pkg::ST_PATTERNS_FULL;
            end else begin
               id = n_patterns++;
               pat_len[id] = ins_len ? ins_len : 1;
               out_id[n] = id;
            end
            ins_node = 0;
            ins_len = 0;
         end
         mpsm_pkg::KIND_BUILD: link_trie();
         mpsm_pkg::KIND_TEXT_START: begin
            cur_node = 0;
            text_pos = 0;
         end
         mpsm_pkg::KIND_TEXT_BYTE: begin
            if (text_pos == NIL) begin
               st = mpsm_pkg::ST_TEXT_LONG;
            end else begin
               node = cur_node < mpsm_pkg::NODES ? cur_node : 0;
               t = find_child(node, sym);
               guard = 0;
               while (t == NIL && node != 0 && guard < mpsm_pkg::NODES) begin
                  node = fail_to[node];
                  if (node == NIL || node >= mpsm_pkg::NODES) node = 0;
                  t = find_child(node, sym);
                  guard++;
               end
               cur_node = (t == NIL) ? 0 : t;
               r = cur_node;
               prev = NIL;
               k = 0;
               guard = 0;
               while (r != NIL && r < mpsm_pkg::NODES && k < mpsm_pkg::MAX_RES &&
                      guard < mpsm_pkg::NODES) begin
                  o = out_id[r];
                  if (o == NIL) break;
                  if (o != prev) begin
                     push_result(mpsm_pkg::ST_MATCH, o, text_pos + 1 - id_length(o), 1'b0);
                     k++;
                     prev = o;
                  end
                  r = fail_to[r];
                  guard++;
               end
               text_pos++;
               if (k > 0) begin
                  expected_results[$].last = 1'b1;
                  return;
               end
            end
         end
         default: ;
      endcase
      push_result(st, id, 0, 1'b1);
   endfunction

   task automatic send_request(input logic [mpsm_pkg::KIND_W-1:0] kind,
                               input logic [mpsm_pkg::SYM_W-1:0] sym);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      predict_matches(kind, sym);
      req_ch.valid  <= 1'b1;
      req_ch.kind   <= kind;
      req_ch.symbol <= sym;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_request(mpsm_pkg::KIND_PATTERN_BYTE, s[i]);
      send_request(mpsm_pkg::KIND_PATTERN_END, 8'($urandom));
   endtask

   task automatic send_bytes(input string s);
      for (int i = 0; i < s.len(); i++) send_request(mpsm_pkg::KIND_TEXT_BYTE, s[i]);
   endtask

   task automatic send_text(input string s);
      send_request(mpsm_pkg::KIND_TEXT_START, 8'($urandom));
      send_bytes(s);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (((cycles / 300) % 3) == 0) begin
         rsp_ch.ready <= 1'b1;
      end else if (((cycles / 300) % 3) == 1) begin
         rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 4) == 0);
      end
   end

   always @(posedge clock) begin
      match_result_type m;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("multi_pattern_string_matcher_core test failed");
         $finish;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected response status=%0d id=%0d start=%0d last=%0b", $time,
                     rsp_ch.status, rsp_ch.pattern_id, rsp_ch.start_position, rsp_ch.last);
            errors++;
         end else begin
            m = expected_results.pop_front();
            if (rsp_ch.status !== m.status || rsp_ch.pattern_id !== m.id ||
                rsp_ch.start_position !== m.start || rsp_ch.last !== m.last) begin
               $display("%0t: expected status=%0d id=%0d start=%0d last=%0b", $time,
                        m.status, m.id, m.start, m.last);
               $display("%0t: actual   status=%0d id=%0d start=%0d last=%0b", $time,
                        rsp_ch.status, rsp_ch.pattern_id, rsp_ch.start_position,
                        rsp_ch.last);
               errors++;
            end
         end
      end
   end

   task automatic test_classic_dictionary();
      string long_pat;
      send_request(mpsm_pkg::KIND_CLEAR, 8'hFF);
      send_string("he");
      send_string("she");
      send_string("his");
      send_string("hers");
      send_string("she");
      send_request(mpsm_pkg::KIND_BUILD, 8'h00);
      send_text("ushers");
      send_request(3'd6, 8'hAA);
      send_request(3'd7, 8'h55);
      // Patterns added after the build have no failure links until the next one.
      send_request(mpsm_pkg::KIND_PATTERN_BYTE, 8'h00);
      send_request(mpsm_pkg::KIND_PATTERN_BYTE, 8'hFF);
      send_request(mpsm_pkg::KIND_PATTERN_END, 8'h00);
      send_request(mpsm_pkg::KIND_PATTERN_END, 8'h00);
      send_text("xhe");
      send_request(mpsm_pkg::KIND_TEXT_BYTE, 8'h00);
      send_request(mpsm_pkg::KIND_TEXT_BYTE, 8'hFF);
      send_bytes("hers");
      send_request(mpsm_pkg::KIND_BUILD, 8'h00);
      send_request(mpsm_pkg::KIND_TEXT_START, 8'h00);
      send_request(mpsm_pkg::KIND_TEXT_BYTE, 8'h00);
      send_request(mpsm_pkg::KIND_TEXT_BYTE, 8'hFF);
      send_bytes("she");
      long_pat = "";
      for (int i = 0; i < mpsm_pkg::MAX_LEN + 2; i++) long_pat = {long_pat, "a"};
      send_string(long_pat);
      send_request(mpsm_pkg::KIND_BUILD, 8'h00);
      send_text("aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa");
   endtask

   task automatic test_random_dictionaries();
      int unsigned sent;
      string alphabet;
      string s;
      sent = 0;
      while (sent < 90) begin
         send_request(mpsm_pkg::KIND_CLEAR, 8'($urandom));
         alphabet = ($urandom_range(0, 3) == 0) ? "abcdefgh" : "ab";
         repeat ($urandom_range(2, 7)) begin
            s = "";
            repeat ($urandom_range(0, 5))
               s = {s, alphabet[$urandom_range(0, alphabet.len() - 1)]};
            if ($urandom_range(0, 5) == 0) s = {s, 8'($urandom)};
            send_string(s);
            sent += s.len() + 1;
         end
         send_request(mpsm_pkg::KIND_BUILD, 8'($urandom));
         repeat ($urandom_range(1, 2)) begin
            send_request(mpsm_pkg::KIND_TEXT_START, 8'($urandom));
            repeat ($urandom_range(8, 25)) begin
               if ($urandom_range(0, 15) == 0)
                  send_request(3'($urandom_range(0, 7)) | 3'd1, 8'($urandom));
               else if ($urandom_range(0, 9) == 0)
                  send_request(mpsm_pkg::KIND_TEXT_BYTE, 8'($urandom));
               else
                  send_request(mpsm_pkg::KIND_TEXT_BYTE,
                               alphabet[$urandom_range(0, alphabet.len() - 1)]);
               sent++;
            end
         end
      end
   endtask

   initial begin
      req_ch.valid  = 1'b0;
      req_ch.kind   = mpsm_pkg::KIND_CLEAR;
      req_ch.symbol = '0;
      trie_clear();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_classic_dictionary();
      test_random_dictionaries();
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("multi_pattern_string_matcher_core test passed");
      end else begin
         $display("multi_pattern_string_matcher_core test failed");
      end
      $finish;
   end

endmodule
